[hw/rtl/gpio_command_port_controller_top_defines.svh]
// ----------------------------------------------------------------------------
// GPIO command port controller assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GPIO_COMMAND_PORT_CONTROLLER_TOP_DEFINES_SVH
`define GPIO_COMMAND_PORT_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication.
`define GCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gcp assertion failed");

// Next-cycle implication.
`define GCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gcp assertion failed");

`endif

[hw/rtl/gcp_pkg.sv]
// ----------------------------------------------------------------------------
// GPIO command port controller package
// Item types, command codes and the logical pin to port bit mapping.
// ----------------------------------------------------------------------------
package gcp_pkg;

  localparam int unsigned VecW     = 24;
  localparam int unsigned PinNumW  = 8;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned PinCount = 20;

  typedef enum logic [2:0] {
    CMD_WHOLE_SET  = 3'd0,
    CMD_WHOLE_GET  = 3'd1,
    CMD_MODE_SET   = 3'd2,
    CMD_PIN_SET    = 3'd3,
    CMD_PIN_GET    = 3'd4,
    CMD_MASKED_SET = 3'd5,
    CMD_PINS_GET   = 3'd6,
    CMD_OTHER      = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic               pull_up_enable;
    logic [VecW-1:0]    direction_bits;
    logic [VecW-1:0]    drive_mode_bits;
    logic [VecW-1:0]    level_bits;
    logic [VecW-1:0]    write_mask;
    logic [PinNumW-1:0] pin_number;
    logic               pin_is_output;
    logic               pin_push_pull;
    logic               pin_level;
    logic [VecW-1:0]    pad_levels;
  } gcp_in_t;

  typedef struct packed {
    logic            pull_up_state;
    logic [VecW-1:0] direction_state;
    logic [VecW-1:0] drive_mode_state;
    logic [VecW-1:0] read_levels;
    logic            pin_read_value;
    logic [VecW-1:0] latch_state;
  } gcp_out_t;

  // Port bit of a logical pin: pins 0-3 on port2, 4-11 on port1, 12-19 on port0.
  function automatic logic [BitIdxW-1:0] pin_bit(input logic [PinNumW-1:0] pin);
    logic [PinNumW-1:0] b;
    begin
      if (pin < 8'd4) begin
        b = pin + 8'd16;
      end else if (pin < 8'd12) begin
        b = pin + 8'd4;
      end else if (pin < 8'd20) begin
        b = pin - 8'd12;
      end else begin
        b = pin & 8'd23;
      end
      return b[BitIdxW-1:0];
    end
  endfunction

  function automatic logic pin_valid(input logic [PinNumW-1:0] pin);
    return (pin < PinNumW'(PinCount)) && (pin < PinNumW'(VecW));
  endfunction

  // Port bits that carry a logical pin.
  function automatic logic [VecW-1:0] valid_bits();
    logic [VecW-1:0] v;
    begin
      v = '0;
      for (int p = 0; p < VecW; p++) begin
        if (p < PinCount) begin
          v[pin_bit(PinNumW'(p))] = 1'b1;
        end
      end
      return v;
    end
  endfunction

  localparam logic [VecW-1:0] PinBitsValid = valid_bits();

endpackage

[hw/rtl/gcp_in_if.sv]
// ----------------------------------------------------------------------------
// GPIO command item channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface gcp_in_if;
  logic            valid;
  logic            ready;
  gcp_pkg::gcp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/gcp_out_if.sv]
// ----------------------------------------------------------------------------
// GPIO result item channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface gcp_out_if;
  logic             valid;
  logic             ready;
  gcp_pkg::gcp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/gpio_command_port_controller_top.sv]
// ----------------------------------------------------------------------------
// GPIO command port controller
// Command-driven controller for 20 logical pins on three 8-bit ports.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : command items (whole set/get, mode set, pin set/get, masked set,
//           pins get). One item in, exactly one result item out.
//   out_o : result items with the pin state after the command plus the pad
//           levels read by the command.
//   Latency: a result is valid the cycle after its item is accepted.
//   Throughput: one item per cycle; the single result register is refilled
//   in the same cycle its item is taken, so ready stays high while the
//   receiver keeps taking results.
//   Stall: while a result waits and out_o.ready is low, in_i.ready drops and
//   the result register and pin state hold.
//   Reset: latch all ones, all pins inputs, push-pull cleared, pull-ups on,
//   no result pending. No clearing pass; items are taken right after reset.
//   Timing: one 24-bit mask update and a small pin-number decode sit
//   between the state registers and the result register.
// ----------------------------------------------------------------------------
`include "gpio_command_port_controller_top_defines.svh"

module gpio_command_port_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcp_in_if.sink     in_i,
  gcp_out_if.source  out_o
);

  localparam logic [gcp_pkg::VecW-1:0] AllOnes = '1;

  // Pin state
  logic [gcp_pkg::VecW-1:0] latch_q, latch_d;
  logic [gcp_pkg::VecW-1:0] dir_q, dir_d;
  logic [gcp_pkg::VecW-1:0] pp_q, pp_d;
  logic                     pu_q, pu_d;

  // Result register
  gcp_pkg::gcp_out_t        res_q, res_d;
  logic                     res_valid_q;

  logic                     accept;
  logic [gcp_pkg::BitIdxW-1:0] sel_bit;
  logic                     sel_ok;
  logic [gcp_pkg::VecW-1:0] sel_m;
  logic [gcp_pkg::VecW-1:0] msk;
  logic [gcp_pkg::VecW-1:0] rd;
  logic                     prd;

  // Result register frees up in the cycle its content is taken.
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign sel_bit = gcp_pkg::pin_bit(in_i.data.pin_number);
  assign sel_ok  = gcp_pkg::pin_valid(in_i.data.pin_number);
  assign sel_m   = gcp_pkg::VecW'(1) << sel_bit;
  // Only mask bits that carry a logical pin act in a masked set.
  assign msk     = in_i.data.write_mask & gcp_pkg::PinBitsValid;

  always_comb begin
    latch_d = latch_q;
    dir_d   = dir_q;
    pp_d    = pp_q;
    pu_d    = pu_q;
    rd      = '0;
    prd     = 1'b0;
    case (gcp_pkg::cmd_e'(in_i.data.command))
      gcp_pkg::CMD_WHOLE_SET: begin
        pu_d    = in_i.data.pull_up_enable;
        dir_d   = in_i.data.direction_bits;
        pp_d    = in_i.data.drive_mode_bits & in_i.data.direction_bits;
        latch_d = in_i.data.level_bits | ~in_i.data.direction_bits;
        rd      = in_i.data.pad_levels;
      end
      gcp_pkg::CMD_WHOLE_GET, gcp_pkg::CMD_PINS_GET: begin
        rd = in_i.data.pad_levels;
      end
      gcp_pkg::CMD_MODE_SET: begin
        if (sel_ok) begin
          dir_d = in_i.data.pin_is_output ? (dir_q | sel_m) : (dir_q & ~sel_m);
          pp_d  = (in_i.data.pin_is_output && in_i.data.pin_push_pull) ?
                  (pp_q | sel_m) : (pp_q & ~sel_m);
          // Inputs hold their latch bit at 1.
          latch_d = (in_i.data.pin_is_output && !in_i.data.pin_level) ?
                    (latch_q & ~sel_m) : (latch_q | sel_m);
        end
      end
      gcp_pkg::CMD_PIN_SET: begin
        if (sel_ok) begin
          latch_d = (((dir_q & sel_m) != '0) && !in_i.data.pin_level) ?
                    (latch_q & ~sel_m) : (latch_q | sel_m);
        end
      end
      gcp_pkg::CMD_PIN_GET: begin
        if (sel_ok) begin
          prd = in_i.data.pad_levels[sel_bit];
        end
      end
      gcp_pkg::CMD_MASKED_SET: begin
        latch_d = (latch_q & ~msk) | (msk & (~dir_q | in_i.data.level_bits));
        rd      = in_i.data.pad_levels;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d.pull_up_state    = pu_d;
    res_d.direction_state  = dir_d;
    res_d.drive_mode_state = pp_d;
    res_d.read_levels      = rd;
    res_d.pin_read_value   = prd;
    res_d.latch_state      = latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= AllOnes;
      dir_q       <= '0;
      pp_q        <= '0;
      pu_q        <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        latch_q     <= latch_d;
        dir_q       <= dir_d;
        pp_q        <= pp_d;
        pu_q        <= pu_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  // Input pins always hold a latched 1.
  `GCP_ASSERT_NOW(a_input_latch_high, 1'b1, (latch_q | dir_q) == AllOnes)
  // Push-pull only on outputs.
  `GCP_ASSERT_NOW(a_pp_on_outputs, 1'b1, (pp_q & ~dir_q) == '0)
  // A pending result reports the live pin state.
  `GCP_ASSERT_NOW(a_result_tracks_state, res_valid_q,
                  (res_q.latch_state == latch_q) && (res_q.direction_state == dir_q))
  // A pin read and a port read never come from one command.
  `GCP_ASSERT_NOW(a_single_read_kind, res_valid_q && res_q.pin_read_value,
                  res_q.read_levels == '0)
  // Without an accepted item the pin state holds.
  `GCP_ASSERT_NEXT(a_state_holds, !accept, $stable(latch_q) && $stable(dir_q))

endmodule

[sim/gcp_result_checker.sv]
// ----------------------------------------------------------------------------
// GPIO command port controller result checker
// Watches both channels, keeps its own copy of the pin state and compares
// every result item with the reply predicted for its command.
// ----------------------------------------------------------------------------
module gcp_result_checker
  import gcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gcp_in_if           cmd_mon_i,
  gcp_out_if          res_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [VecW-1:0] latch_q;
  logic [VecW-1:0] dir_q;
  logic [VecW-1:0] pp_q;
  logic            pu_q;
  gcp_out_t        awaited_replies[$];
  int unsigned     mismatches;

  // Called for any pin number; the result is used only for pins below PinCount.
  function automatic logic [BitIdxW-1:0] port_bit_of(logic [PinNumW-1:0] pin);
    if (pin < 4) return BitIdxW'(pin + 16);
    if (pin < 12) return BitIdxW'(pin + 4);
    return BitIdxW'(pin - 12);
  endfunction

  // Inputs keep their latch bit high whatever level is asked for.
  function automatic void drive_latch_bit(logic [BitIdxW-1:0] b, logic level);
    latch_q[b] = !dir_q[b] || level;
  endfunction

  function automatic gcp_out_t run_command(gcp_in_t c);
    gcp_out_t            r;
    logic [BitIdxW-1:0]  b;
    logic                ok;
    r  = '0;
    ok = c.pin_number < PinCount;
    b  = port_bit_of(c.pin_number);
    case (cmd_e'(c.command))
      CMD_WHOLE_SET: begin
        pu_q    = c.pull_up_enable;
        dir_q   = c.direction_bits;
        pp_q    = c.drive_mode_bits & c.direction_bits;
        latch_q = c.level_bits | ~c.direction_bits;
        r.read_levels = c.pad_levels;
      end
      CMD_WHOLE_GET, CMD_PINS_GET: begin
        r.read_levels = c.pad_levels;
      end
      CMD_MODE_SET: begin
        if (ok) begin
          dir_q[b] = c.pin_is_output;
          pp_q[b]  = c.pin_is_output && c.pin_push_pull;
          drive_latch_bit(b, c.pin_level);
        end
      end
      CMD_PIN_SET: begin
        if (ok) drive_latch_bit(b, c.pin_level);
      end
      CMD_PIN_GET: begin
        if (ok) r.pin_read_value = c.pad_levels[b];
      end
      CMD_MASKED_SET: begin
        // Mask bits without a logical pin (port2 bits 4-7) do nothing.
        for (int p = 0; p < PinCount; p++) begin
          b = port_bit_of(PinNumW'(p));
          if (c.write_mask[b]) drive_latch_bit(b, c.level_bits[b]);
        end
        r.read_levels = c.pad_levels;
      end
      default: begin
      end
    endcase
    r.pull_up_state    = pu_q;
    r.direction_state  = dir_q;
    r.drive_mode_state = pp_q;
    r.latch_state      = latch_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [VecW-1:0] want,
                                      logic [VecW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    gcp_out_t want;
    if (!rst_ni) begin
      latch_q      = '1;
      dir_q        = '0;
      pp_q         = '0;
      pu_q         = 1'b1;
      mismatches   = 0;
      awaited_replies.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare before predicting: a reply never leaves on its own command's edge.
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result expected none got %h", $time, res_mon_i.data);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("pull_up_state", want.pull_up_state, res_mon_i.data.pull_up_state);
          check_field("direction_state", want.direction_state,
                      res_mon_i.data.direction_state);
          check_field("drive_mode_state", want.drive_mode_state,
                      res_mon_i.data.drive_mode_state);
          check_field("read_levels", want.read_levels, res_mon_i.data.read_levels);
          check_field("pin_read_value", want.pin_read_value,
                      res_mon_i.data.pin_read_value);
          check_field("latch_state", want.latch_state, res_mon_i.data.latch_state);
        end
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        awaited_replies.push_back(run_command(cmd_mon_i.data));
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_replies.size();
    end
  end

endmodule

[sim/gpio_command_port_controller_top_test.sv]
// ----------------------------------------------------------------------------
// GPIO command port controller testbench
// Directed commands on pin edges and special cases, then random commands
// under changing sender gaps and receiver stalls; results are checked by
// the result checker beside the block.
// ----------------------------------------------------------------------------
module gpio_command_port_controller_top_test;
  import gcp_pkg::*;

  localparam int unsigned RandomItems = 500;
  // Cycles with no accepted item before the run is declared hung. Gaps and
  // stalls are geometric with p <= 0.74, so a run of this length never
  // happens in a working block.
  localparam int unsigned HangLimit   = 2000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned expect_count;
  int unsigned quiet_cycles;

  gcp_in_if  cmd_ch ();
  gcp_out_if rsp_ch ();

  gpio_command_port_controller_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (rsp_ch)
  );

  gcp_result_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon_i    (cmd_ch),
    .res_mon_i    (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (expect_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: ready redrawn every cycle, low for recv_stall_pct percent.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detection: counts edges at which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random command with random content. Most pins are real ones so that
  // the state gets exercised; the rest reach every bit of pin_number.
  function automatic gcp_in_t rand_item(cmd_e c);
    gcp_in_t it;
    it.command         = c;
    it.pull_up_enable  = 1'($urandom_range(1));
    it.direction_bits  = VecW'($urandom);
    it.drive_mode_bits = VecW'($urandom);
    it.level_bits      = VecW'($urandom);
    it.write_mask      = VecW'($urandom);
    it.pin_is_output   = 1'($urandom_range(1));
    it.pin_push_pull   = 1'($urandom_range(1));
    it.pin_level       = 1'($urandom_range(1));
    it.pad_levels      = VecW'($urandom);
    if ($urandom_range(99) < 80) it.pin_number = PinNumW'($urandom_range(PinCount - 1));
    else it.pin_number = PinNumW'($urandom_range(255, PinCount));
    return it;
  endfunction

  // Offers one item after a random gap and returns on the edge that takes it.
  // valid stays high on return, so back-to-back items need no extra edge.
  task automatic send_item(input gcp_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  // Holds the sender off until every predicted reply has come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expect_count != 0) @(posedge clk_i);
  endtask

  initial begin
    gcp_in_t it;
    cmd_ch.valid   = 1'b0;
    cmd_ch.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, no idling ----
    // Reads straight after reset, first and last pin, then an invalid pin.
    it = rand_item(CMD_PIN_GET);  it.pin_number = 8'd0;   it.pad_levels = '1; send_item(it);
    it = rand_item(CMD_PIN_GET);  it.pin_number = 8'd19;  it.pad_levels = '0; send_item(it);
    it = rand_item(CMD_PIN_GET);  it.pin_number = 8'd255; it.pad_levels = '1; send_item(it);
    it = rand_item(CMD_WHOLE_GET); it.pad_levels = 24'hA5A5A5; send_item(it);
    // Pin set on an input: latch bit must stay high.
    it = rand_item(CMD_PIN_SET);  it.pin_number = 8'd3; it.pin_level = 1'b0; send_item(it);
    // Everything output, push-pull, driven low, pull-ups off.
    it = rand_item(CMD_WHOLE_SET);
    it.pull_up_enable  = 1'b0;
    it.direction_bits  = '1;
    it.drive_mode_bits = '1;
    it.level_bits      = '0;
    send_item(it);
    it = rand_item(CMD_PIN_SET);  it.pin_number = 8'd0;  it.pin_level = 1'b1; send_item(it);
    it = rand_item(CMD_PIN_SET);  it.pin_number = 8'd19; it.pin_level = 1'b1; send_item(it);
    it = rand_item(CMD_PIN_SET);  it.pin_number = 8'd20; it.pin_level = 1'b1; send_item(it);
    // Mode set: to input with push-pull asked (must clear), open drain, push-pull.
    it = rand_item(CMD_MODE_SET);
    it.pin_number = 8'd4;  it.pin_is_output = 1'b0; it.pin_push_pull = 1'b1; it.pin_level = 1'b0;
    send_item(it);
    it = rand_item(CMD_MODE_SET);
    it.pin_number = 8'd12; it.pin_is_output = 1'b1; it.pin_push_pull = 1'b0; it.pin_level = 1'b0;
    send_item(it);
    it = rand_item(CMD_MODE_SET);
    it.pin_number = 8'd11; it.pin_is_output = 1'b1; it.pin_push_pull = 1'b1; it.pin_level = 1'b1;
    send_item(it);
    it = rand_item(CMD_MODE_SET); it.pin_number = 8'd200; send_item(it);
    // Masked set with a full mask: port2 bits 4-7 have no pin and must stay low.
    it = rand_item(CMD_MASKED_SET); it.write_mask = '1; it.level_bits = '1; send_item(it);
    it = rand_item(CMD_MASKED_SET); it.write_mask = '1; it.level_bits = '0; send_item(it);
    it = rand_item(CMD_MASKED_SET); it.write_mask = '0; it.level_bits = '1; send_item(it);
    it = rand_item(CMD_PINS_GET); it.pad_levels = '1; send_item(it);
    it = rand_item(CMD_OTHER); send_item(it);
    // All inputs with push-pull requested: push-pull must come back clear.
    it = rand_item(CMD_WHOLE_SET);
    it.pull_up_enable  = 1'b1;
    it.direction_bits  = '0;
    it.drive_mode_bits = '1;
    it.level_bits      = '0;
    send_item(it);
    it = rand_item(CMD_MODE_SET);
    it.pin_number = 8'd7; it.pin_is_output = 1'b1; it.pin_push_pull = 1'b1; it.pin_level = 1'b0;
    send_item(it);

    // Sender holds off until the block has answered everything.
    drain_results();

    // ---- random part: no idling, sender gaps, receiver stalls, both ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < RandomItems / 4; n++) begin
        send_item(rand_item(cmd_e'($urandom_range(7))));
        if (ph == 2 && n == RandomItems / 8) drain_results();
      end
    end

    drain_results();
    // Wait on so that any stray result is caught.
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && expect_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
